// ----- rtl/core/length_checksum_frame_deframer_defines.svh -----
// Assertion helpers shared by the deframer RTL.
`ifndef LENGTH_CHECKSUM_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_CHECKSUM_FRAME_DEFRAMER_DEFINES_SVH

// Checked outside reset only.
`define LCFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define LCFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/core/lcfd_pkg.sv -----
`default_nettype none

package lcfd_pkg;

  localparam int MAX_FRAME_SIZE = 256;
  localparam int POS_W          = $clog2(MAX_FRAME_SIZE + 1);
  localparam int LEN_W          = 17;
  localparam int SIZE_W         = 9;
  localparam int SIZE_CAP       = 256;
  localparam int HDR_OVERHEAD   = 6;
  localparam int SUM_FIRST      = 3;
  localparam int PAY_FIRST      = 6;
  localparam int PAY_LAST       = 13;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int TOK_DEPTH = 2;
  localparam int TOK_PTR_W = (TOK_DEPTH > 1) ? $clog2(TOK_DEPTH) : 1;
  localparam int TOK_CNT_W = $clog2(TOK_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_END_MARKER   = 2'd1,
    CFG_MIN_SIZE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_SUM_ERR = 2'd2,
    ST_END_ERR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TOK_START   = 2'd0,
    TOK_DATA    = 2'd1,
    TOK_LEN_ERR = 2'd2
  } tok_op_e;

  // One classified byte: what the back end must do with it.
  typedef struct packed {
    tok_op_e           op;
    logic [7:0]        data;
    logic              hdr_en;
    logic [1:0]        hdr_idx;
    logic              pay_en;
    logic [2:0]        pay_idx;
    logic              sum_add;
    logic              sum_low;
    logic              sum_chk;
    logic              last;
    logic [SIZE_W-1:0] size;
  } tok_t;

endpackage

`default_nettype wire

// ----- rtl/core/length_checksum_frame_deframer.sv -----
// Length-prefixed frame deframer with a 16-bit additive checksum.
// Input channel: one received byte per transfer (push/full). Bytes are hunted
// for the start marker, then a little-endian length L gives frame size L+6.
// Result channel (empty/pop): one record per finished frame or per rejected
// length, carrying status, header bytes 3..5, saturated size and payload 6..13.
// Configuration: cfg_we_i writes start marker (0), end marker (1) and minimum
// frame size (2); write only while no frame is in flight.
// Throughput: one byte per cycle while full is low. A classifier in front tags each
// byte with its role and hands it through a two-entry token queue to the
// accumulator, which owns the single output register.
// Result path: the token of a frame's last byte is written into the queue; the
// accumulator then registers the result in the output register.
// Reset: clears position, queue and output valid; registers return to 0xA5, 0x0D, 9.
// Receiver stall: a held result blocks only the next result-bearing token; the
// queue then fills and full rises after one more classified byte, until pop.
`default_nettype none

module length_checksum_frame_deframer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      rx_byte_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [1:0]                           status_o,
  output logic [7:0]                           msg_type_o,
  output logic [7:0]                           source_id_o,
  output logic [7:0]                           dest_id_o,
  output logic [8:0]                           frame_size_o,
  output logic [63:0]                          payload_head_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lcfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lcfd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lcfd_pkg::*;

  logic [7:0] start_marker_q;
  logic [7:0] end_marker_q;
  logic [8:0] min_size_q;
  tok_t       push_tok, pop_tok;
  logic       tok_push, tok_full, tok_valid, tok_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= 8'hA5;
      end_marker_q   <= 8'h0D;
      min_size_q     <= 9'd9;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_MARKER: start_marker_q <= cfg_wdata_i[7:0];
        CFG_END_MARKER:   end_marker_q   <= cfg_wdata_i[7:0];
        CFG_MIN_SIZE:     min_size_q     <= cfg_wdata_i[8:0];
        default: begin
        end
      endcase
    end
  end

  assign full = tok_full;

  lcfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .rx_byte_i      (rx_byte_i),
    .start_marker_i (start_marker_q),
    .min_size_i     (min_size_q),
    .tok_full_i     (tok_full),
    .tok_o          (push_tok),
    .tok_push_o     (tok_push)
  );

  lcfd_tok_fifo u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tok_push),
    .wdata_i (push_tok),
    .full_o  (tok_full),
    .rd_i    (tok_pop),
    .rdata_o (pop_tok),
    .valid_o (tok_valid)
  );

  lcfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_i          (pop_tok),
    .tok_valid_i    (tok_valid),
    .tok_pop_o      (tok_pop),
    .end_marker_i   (end_marker_q),
    .pop_i          (pop),
    .empty_o        (empty),
    .status_o       (status_o),
    .msg_type_o     (msg_type_o),
    .source_id_o    (source_id_o),
    .dest_id_o      (dest_id_o),
    .frame_size_o   (frame_size_o),
    .payload_head_o (payload_head_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/lcfd_front.sv -----
`default_nettype none
`include "length_checksum_frame_deframer_defines.svh"

module lcfd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic [7:0]         start_marker_i,
  input  wire logic [8:0]         min_size_i,
  input  wire logic               tok_full_i,
  output lcfd_pkg::tok_t          tok_o,
  output logic                    tok_push_o
);
  import lcfd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] size_q, size_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic [LEN_W-1:0] len_full;
  logic             len_bad;
  logic             accept;
  logic             want_tok;
  logic [POS_W-1:0] hdr_off;
  logic [POS_W-1:0] pay_off;

  function automatic logic [SIZE_W-1:0] sat_size(input logic [LEN_W-1:0] s);
    return (s > LEN_W'(SIZE_CAP)) ? SIZE_W'(SIZE_CAP) : s[SIZE_W-1:0];
  endfunction

  assign len_full = LEN_W'({rx_byte_i, len_lo_q}) + LEN_W'(HDR_OVERHEAD);
  assign len_bad  = (len_full < LEN_W'(min_size_i)) ||
                    (len_full > LEN_W'(MAX_FRAME_SIZE));
  assign accept   = push_i && !tok_full_i;
  assign hdr_off  = pos_q - POS_W'(SUM_FIRST);
  assign pay_off  = pos_q - POS_W'(PAY_FIRST);

  always_comb begin
    tok_o      = '0;
    tok_o.op   = TOK_DATA;
    tok_o.data = rx_byte_i;
    tok_o.size = sat_size(LEN_W'(size_q));
    want_tok   = 1'b0;
    pos_d      = pos_q;
    size_d     = size_q;
    len_lo_d   = len_lo_q;
    if (pos_q == '0) begin
      tok_o.op = TOK_START;
      want_tok = (rx_byte_i == start_marker_i);
      if (want_tok) begin
        pos_d = POS_W'(1);
      end
    end else if (pos_q == POS_W'(1)) begin
      len_lo_d = rx_byte_i;
      pos_d    = POS_W'(2);
    end else if (pos_q == POS_W'(2)) begin
      size_d     = len_full[POS_W-1:0];
      tok_o.op   = TOK_LEN_ERR;
      tok_o.size = sat_size(len_full);
      want_tok   = len_bad;
      pos_d      = len_bad ? '0 : POS_W'(SUM_FIRST);
    end else begin
      want_tok      = 1'b1;
      tok_o.hdr_en  = (pos_q < POS_W'(PAY_FIRST));
      tok_o.hdr_idx = hdr_off[1:0];
      tok_o.pay_en  = (pos_q >= POS_W'(PAY_FIRST)) && (pos_q <= POS_W'(PAY_LAST));
      tok_o.pay_idx = pay_off[2:0];
      tok_o.sum_add = (pos_q <= size_q - POS_W'(4));
      tok_o.sum_low = (pos_q == size_q - POS_W'(3));
      tok_o.sum_chk = (pos_q == size_q - POS_W'(2));
      tok_o.last    = (pos_q == size_q - POS_W'(1));
      pos_d         = tok_o.last ? '0 : pos_q + POS_W'(1);
    end
  end

  assign tok_push_o = accept && want_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q   <= size_d;
      len_lo_q <= len_lo_d;
    end
  end

  `LCFD_ASSERT(a_pos_in_frame, (pos_q >= POS_W'(SUM_FIRST)) |-> (pos_q < size_q), "position past frame end")
  `LCFD_ASSERT(a_len_err_rehunt, (tok_push_o && tok_o.op == TOK_LEN_ERR) |=> (pos_q == '0), "no rehunt after length error")
  `LCFD_ASSERT(a_no_push_full, tok_full_i |-> !tok_push_o, "token pushed into full queue")

endmodule

`default_nettype wire

// ----- rtl/core/lcfd_tok_fifo.sv -----
`default_nettype none
`include "length_checksum_frame_deframer_defines.svh"

module lcfd_tok_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  wire lcfd_pkg::tok_t wdata_i,
  output logic                full_o,
  input  wire logic           rd_i,
  output lcfd_pkg::tok_t      rdata_o,
  output logic                valid_o
);
  import lcfd_pkg::*;

  tok_t                 mem_q [TOK_DEPTH];
  logic [TOK_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [TOK_CNT_W-1:0] cnt_q;
  logic                 do_wr, do_rd;

  function automatic logic [TOK_PTR_W-1:0] next_ptr(input logic [TOK_PTR_W-1:0] p);
    return (p == TOK_PTR_W'(TOK_DEPTH - 1)) ? '0 : p + TOK_PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == TOK_CNT_W'(TOK_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + TOK_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - TOK_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `LCFD_ASSERT(a_cnt_bound, cnt_q <= TOK_CNT_W'(TOK_DEPTH), "token count overflow")

endmodule

`default_nettype wire

// ----- rtl/core/lcfd_back.sv -----
`default_nettype none
`include "length_checksum_frame_deframer_defines.svh"

module lcfd_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lcfd_pkg::tok_t               tok_i,
  input  wire logic                         tok_valid_i,
  output logic                              tok_pop_o,
  input  wire logic [7:0]                   end_marker_i,
  input  wire logic                         pop_i,
  output logic                              empty_o,
  output logic [1:0]                        status_o,
  output logic [7:0]                        msg_type_o,
  output logic [7:0]                        source_id_o,
  output logic [7:0]                        dest_id_o,
  output logic [lcfd_pkg::SIZE_W-1:0]       frame_size_o,
  output logic [63:0]                       payload_head_o
);
  import lcfd_pkg::*;

  logic [15:0]       sum_q, sum_d;
  logic [7:0]        sum_lo_q, sum_lo_d;
  logic              mism_q, mism_d;
  logic [23:0]       hdr_q, hdr_d;
  logic [63:0]       pay_q, pay_d;
  logic              emit;
  logic              take;
  status_e           st;
  logic              out_valid_q;
  status_e           out_st_q;
  logic [23:0]       out_hdr_q;
  logic [SIZE_W-1:0] out_size_q;
  logic [63:0]       out_pay_q;

  assign emit = (tok_i.op == TOK_LEN_ERR) || ((tok_i.op == TOK_DATA) && tok_i.last);
  // Hold the queue only when a result would land on a full output register that is not being popped.
  assign tok_pop_o = tok_valid_i && (!emit || !out_valid_q || pop_i);
  assign take      = tok_pop_o;

  always_comb begin
    sum_d    = sum_q;
    sum_lo_d = sum_lo_q;
    mism_d   = mism_q;
    hdr_d    = hdr_q;
    pay_d    = pay_q;
    st       = ST_OK;
    case (tok_i.op)
      TOK_START: begin
        sum_d    = '0;
        sum_lo_d = '0;
        mism_d   = 1'b0;
        hdr_d    = '0;
        pay_d    = '0;
      end
      TOK_LEN_ERR: begin
        st    = ST_LEN_ERR;
        hdr_d = '0;
        pay_d = '0;
      end
      TOK_DATA: begin
        if (tok_i.hdr_en) begin
          hdr_d[8*tok_i.hdr_idx +: 8] = tok_i.data;
        end
        if (tok_i.pay_en) begin
          pay_d[8*tok_i.pay_idx +: 8] = tok_i.data;
        end
        if (tok_i.sum_add) begin
          sum_d = sum_q + 16'(tok_i.data);
        end
        if (tok_i.sum_low) begin
          sum_lo_d = tok_i.data;
        end
        if (tok_i.sum_chk) begin
          mism_d = ({tok_i.data, sum_lo_q} != sum_q);
        end
        if (mism_q) begin
          st = ST_SUM_ERR;
        end else if (tok_i.data != end_marker_i) begin
          st = ST_END_ERR;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sum_q    <= sum_d;
      sum_lo_q <= sum_lo_d;
      mism_q   <= mism_d;
      hdr_q    <= hdr_d;
      pay_q    <= pay_d;
    end
    if (take && emit) begin
      out_st_q   <= st;
      out_hdr_q  <= hdr_d;
      out_size_q <= tok_i.size;
      out_pay_q  <= pay_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && emit) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o        = !out_valid_q;
  assign status_o       = out_st_q;
  assign msg_type_o     = out_hdr_q[7:0];
  assign source_id_o    = out_hdr_q[15:8];
  assign dest_id_o      = out_hdr_q[23:16];
  assign frame_size_o   = out_size_q;
  assign payload_head_o = out_pay_q;

  `LCFD_ASSERT(a_emit_lands, (take && emit) |=> !empty_o, "result lost on output register")

endmodule

`default_nettype wire

// ----- test/length_checksum_frame_deframer_test.sv -----
`timescale 1ns / 100ps

module length_checksum_frame_deframer_test;
  import lcfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          PHASE_BYTES  = 200;
  localparam int          PHASE_COUNT  = 8;
  localparam int          SETTLE_TICKS = 8;

  typedef struct packed {
    status_e     status;
    logic [7:0]  msg_type;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
    logic [8:0]  frame_size;
    logic [63:0] payload_head;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        pop = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_idx = CFG_START_MARKER;
  logic [8:0]  cfg_wdata = 9'h000;
  logic        full;
  logic        empty;
  logic [1:0]  status_o;
  logic [7:0]  msg_type_o;
  logic [7:0]  source_id_o;
  logic [7:0]  dest_id_o;
  logic [8:0]  frame_size_o;
  logic [63:0] payload_head_o;

  // Register copies, as the block holds them after reset.
  logic [7:0]  cfg_start = 8'hA5;
  logic [7:0]  cfg_end = 8'h0D;
  logic [8:0]  cfg_min = 9'd9;

  // Deframer state mirror.
  int          frame_pos = 0;
  int          frame_len_seen = 0;
  logic [7:0]  len_low = 8'h00;
  logic [15:0] run_sum = 16'h0000;
  logic [7:0]  sum_low = 8'h00;
  logic [23:0] hdr_bytes = 24'h0;
  logic [63:0] pay_window = 64'h0;
  logic        sum_bad = 1'b0;

  logic [7:0]    rx_byte_q [$];
  frame_result_t frame_result_q [$];
  int            bytes_queued = 0;
  int            send_gap = 0;
  int            pop_gap = 0;
  int            errors = 0;
  int unsigned   cycle_count = 0;
  bit            steady_flow = 1'b0;

  length_checksum_frame_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .msg_type_o     (msg_type_o),
    .source_id_o    (source_id_o),
    .dest_id_o      (dest_id_o),
    .frame_size_o   (frame_size_o),
    .payload_head_o (payload_head_o),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    if (errors < 100) $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (steady_flow || r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic void queue_result(status_e st);
    frame_result_t r;
    r.status       = st;
    r.msg_type     = hdr_bytes[7:0];
    r.source_id    = hdr_bytes[15:8];
    r.dest_id      = hdr_bytes[23:16];
    r.frame_size   = (frame_len_seen > SIZE_CAP) ? 9'(SIZE_CAP) : 9'(frame_len_seen);
    r.payload_head = pay_window;
    frame_result_q.push_back(r);
  endfunction

  // Advance the deframer mirror by one accepted byte.
  function automatic void deframe_byte(logic [7:0] b);
    int      p;
    status_e st;
    p = frame_pos;
    if (p == 0) begin
      if (b == cfg_start) begin
        frame_pos      = 1;
        frame_len_seen = 0;
        len_low        = 8'h00;
        run_sum        = 16'h0000;
        sum_low        = 8'h00;
        hdr_bytes      = 24'h0;
        pay_window     = 64'h0;
        sum_bad        = 1'b0;
      end
      return;
    end
    if (p == 1) begin
      len_low   = b;
      frame_pos = 2;
      return;
    end
    if (p == 2) begin
      frame_len_seen = int'({b, len_low}) + HDR_OVERHEAD;
      if (frame_len_seen < cfg_min || frame_len_seen > MAX_FRAME_SIZE) begin
        frame_pos = 0;
        queue_result(ST_LEN_ERR);
      end else begin
        frame_pos = 3;
      end
      return;
    end
    // A byte takes every role that its position has.
    if (p <= 5) hdr_bytes[8*(p-SUM_FIRST) +: 8] = b;
    if (p >= PAY_FIRST && p <= PAY_LAST) pay_window[8*(p-PAY_FIRST) +: 8] = b;
    if (p <= frame_len_seen - 4) run_sum = run_sum + b;
    if (p == frame_len_seen - 3) sum_low = b;
    if (p == frame_len_seen - 2) sum_bad = ({b, sum_low} != run_sum);
    if (p == frame_len_seen - 1) begin
      if (sum_bad) st = ST_SUM_ERR;
      else if (b != cfg_end) st = ST_END_ERR;
      else st = ST_OK;
      frame_pos = 0;
      queue_result(st);
    end else begin
      frame_pos = p + 1;
    end
  endfunction

  task automatic check_frame_result();
    frame_result_t want;
    if (frame_result_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: status %0d size %0d",
                                status_o, frame_size_o));
      return;
    end
    want = frame_result_q.pop_front();
    if (status_o !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
    if (msg_type_o !== want.msg_type)
      report_mismatch($sformatf("msg_type %h, want %h", msg_type_o, want.msg_type));
    if (source_id_o !== want.source_id)
      report_mismatch($sformatf("source_id %h, want %h", source_id_o, want.source_id));
    if (dest_id_o !== want.dest_id)
      report_mismatch($sformatf("dest_id %h, want %h", dest_id_o, want.dest_id));
    if (frame_size_o !== want.frame_size)
      report_mismatch($sformatf("frame_size %0d, want %0d", frame_size_o, want.frame_size));
    if (payload_head_o !== want.payload_head)
      report_mismatch($sformatf("payload_head %h, want %h", payload_head_o,
                                want.payload_head));
  endtask

  // Byte sender: hold a byte while full, then rest for a random gap.
  always @(posedge clk_i or negedge rst_ni) begin : byte_sender
    int g;
    if (!rst_ni) begin
      push     <= 1'b0;
      rx_byte  <= 8'h00;
      send_gap <= 0;
    end else if (!(push && full)) begin
      g = send_gap;
      if (push) begin
        deframe_byte(rx_byte);
        g = draw_gap();
      end
      if (g != 0 || rx_byte_q.size() == 0) begin
        push     <= 1'b0;
        send_gap <= (g != 0) ? g - 1 : 0;
      end else begin
        push     <= 1'b1;
        rx_byte  <= rx_byte_q.pop_front();
        send_gap <= 0;
      end
    end
  end

  // Result receiver: check each transfer, then stall for a random gap.
  always @(posedge clk_i or negedge rst_ni) begin : result_receiver
    int g;
    if (!rst_ni) begin
      pop     <= 1'b0;
      pop_gap <= 0;
    end else if (pop && !empty) begin
      check_frame_result();
      g = draw_gap();
      pop     <= (g == 0);
      pop_gap <= (g == 0) ? 0 : g - 1;
    end else if (pop_gap != 0) begin
      pop     <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [8:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_MARKER: cfg_start = val[7:0];
      CFG_END_MARKER:   cfg_end = val[7:0];
      CFG_MIN_SIZE:     cfg_min = val;
      default: ;
    endcase
  endtask

  // Drain all bytes, finish any open frame with filler, wait out the results.
  task automatic settle();
    forever begin
      while (rx_byte_q.size() != 0 || push) @(negedge clk_i);
      if (frame_pos == 0) break;
      rx_byte_q.push_back(8'($urandom));
      bytes_queued++;
    end
    while (frame_result_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  // Queue one frame of the given total size; keep > 0 truncates it.
  function automatic void queue_frame(int total, bit bad_sum, bit bad_end, int keep);
    logic [7:0]  fr [$];
    logic [15:0] len;
    logic [15:0] sum;
    len = 16'(total - HDR_OVERHEAD);
    sum = 16'h0000;
    fr.push_back(cfg_start);
    fr.push_back(len[7:0]);
    fr.push_back(len[15:8]);
    if (total >= cfg_min && total <= MAX_FRAME_SIZE) begin
      for (int i = SUM_FIRST; i <= total - 4; i++) begin
        fr.push_back(8'($urandom));
        sum = sum + fr[i];
      end
      if (bad_sum) sum = sum ^ 16'($urandom_range(16'hFFFF, 1));
      fr.push_back(sum[7:0]);
      fr.push_back(sum[15:8]);
      fr.push_back(bad_end ? cfg_end ^ 8'($urandom_range(255, 1)) : cfg_end);
    end
    if (keep == 0 || keep > fr.size()) keep = fr.size();
    for (int i = 0; i < keep; i++) rx_byte_q.push_back(fr[i]);
    bytes_queued += keep;
  endfunction

  function automatic int pick_frame_size();
    int span;
    if ($urandom_range(39) == 0) return MAX_FRAME_SIZE;
    span = MAX_FRAME_SIZE - cfg_min;
    if (span > 14) span = 14;
    return cfg_min + $urandom_range(span, 0);
  endfunction

  function automatic int pick_bad_size();
    if (cfg_min > HDR_OVERHEAD && $urandom_range(1) == 0)
      return $urandom_range(cfg_min - 1, HDR_OVERHEAD);
    return $urandom_range(65535 + HDR_OVERHEAD, MAX_FRAME_SIZE + 1);
  endfunction

  initial begin : stimulus
    int pick;
    int phase_end;
    int noise;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Opening bytes: noise, a minimal frame opening with the start byte as data,
    // both checks failing at once, and length fields at both extremes.
    rx_byte_q = {8'hFF,
                 cfg_start, 8'h03, 8'h00, cfg_start, 8'hFF, 8'h00, 8'hA4, 8'h01, cfg_end,
                 cfg_start, 8'h03, 8'h00, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'hFF,
                 cfg_start, 8'h00, 8'h00,
                 cfg_start, 8'hFF, 8'hFF};
    settle();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_START_MARKER, {1'b1, 8'h00});
          write_reg(CFG_END_MARKER, {1'b0, 8'hFF});
          write_reg(CFG_MIN_SIZE, 9'd9);
        end
        1: begin
          write_reg(CFG_START_MARKER, {1'b0, 8'hFF});
          write_reg(CFG_END_MARKER, {1'b1, 8'h00});
          write_reg(CFG_MIN_SIZE, 9'(MAX_FRAME_SIZE));
        end
        default: begin
          write_reg(CFG_START_MARKER, 9'($urandom));
          write_reg(CFG_END_MARKER, 9'($urandom));
          write_reg(CFG_MIN_SIZE, ($urandom_range(3) == 0) ?
                    9'($urandom_range(MAX_FRAME_SIZE, 9)) : 9'($urandom_range(20, 9)));
        end
      endcase
      steady_flow = (ph == 3 || ph == 6);
      phase_end = bytes_queued + PHASE_BYTES;
      while (bytes_queued < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 60) queue_frame(pick_frame_size(), 1'b0, 1'b0, 0);
        else if (pick < 70) queue_frame(pick_frame_size(), 1'b1, 1'($urandom), 0);
        else if (pick < 80) queue_frame(pick_frame_size(), 1'b0, 1'b1, 0);
        else if (pick < 88) queue_frame(pick_bad_size(), 1'b0, 1'b0, 0);
        else if (pick < 94) queue_frame(pick_frame_size(), 1'b0, 1'b0, $urandom_range(8, 1));
        else begin
          noise = $urandom_range(4, 1);
          repeat (noise) rx_byte_q.push_back(8'($urandom));
          bytes_queued += noise;
        end
      end
    end

    steady_flow = 1'b0;
    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
